### src/ows_pkg.sv
// package for the overlap window stacker: sizes, register codes, state codes
// no dependencies
`timescale 1ns / 1ps
package ows_pkg;
  localparam int OUT_SAMPLES_DEF  = 4096;
  localparam int MAX_CHANNELS_DEF = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_STEPS = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STACK_MODE = 2'd0,
    REG_CHANNELS   = 2'd1,
    REG_WIN_LEN    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_DIV, ST_WRITE, ST_OUT
  } ows_state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic rd;
    logic eval;
    logic div_step;
    logic wr;
  } ows_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic err;
    logic skip;
    logic need_div;
  } ows_sts_t;
endpackage

### src/ows_if.sv
// valid/ready channel carrying one word
// depends on nothing
`timescale 1ns / 1ps
interface ows_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/overlap_window_stacker.sv
// top level of the overlap window stacker: interfaces, controller, datapath
// depends on ows_pkg, ows_if, ows_ctrl, ows_dp
// accept to result: range errors READ, OUT; reads and skips READ, EVAL, OUT;
// max updates READ, EVAL, WRITE, OUT; averaging runs the restoring divider in
// DIV before WRITE. One word at a time, the next taken in IDLE once the result
// is accepted. Reset: a clearing pass over all entries zeroes both stores
// before the first word is taken; configuration writes are taken throughout
`timescale 1ns / 1ps
module overlap_window_stacker #(
  parameter int OUT_SAMPLES  = ows_pkg::OUT_SAMPLES_DEF,
  parameter int MAX_CHANNELS = ows_pkg::MAX_CHANNELS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic cfg_we,
  input logic [ows_pkg::CFG_IDX_W-1:0] cfg_idx,
  input logic [ows_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ows_if.sink in_ch,
  ows_if.source out_ch
);
  import ows_pkg::*;
  ows_cmd_t cmd;
  ows_sts_t sts;
  logic signed [15:0] sv;
  logic [15:0] sc;
  logic re;

  // input word: op, offset, index, channel, value, missing (msb first)
  ows_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  ows_dp #(.OUT_SAMPLES(OUT_SAMPLES), .MAX_CHANNELS(MAX_CHANNELS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_operation(in_ch.data[43]),
    .in_window_offset(in_ch.data[42:31]),
    .in_sample_index(in_ch.data[30:19]),
    .in_channel(in_ch.data[18:17]),
    .in_sample_value(in_ch.data[16:1]),
    .in_value_missing(in_ch.data[0]),
    .out_stored_value(sv), .out_hit_count(sc), .out_range_error(re),
    .cmd, .sts
  );

  // output word: value, count, error
  assign out_ch.data = {sv, sc, re};
endmodule

### src/ows_ctrl.sv
// controller state machine for the stacker
// depends on ows_pkg
`timescale 1ns / 1ps
module ows_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  ows_pkg::ows_sts_t sts,
  output ows_pkg::ows_cmd_t cmd
);
  import ows_pkg::*;
  ows_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_nxt = sts.err ? ST_OUT : ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        cnt_nxt = '0;
        if (sts.skip) state_nxt = ST_OUT;
        else if (sts.need_div) state_nxt = ST_DIV;
        else state_nxt = ST_WRITE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### src/ows_dp.sv
// datapath: stores, range check, max compare, restoring divider
// depends on ows_pkg
`timescale 1ns / 1ps
module ows_dp #(
  parameter int OUT_SAMPLES  = ows_pkg::OUT_SAMPLES_DEF,
  parameter int MAX_CHANNELS = ows_pkg::MAX_CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [ows_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ows_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic in_operation,
  input  logic [11:0] in_window_offset,
  input  logic [11:0] in_sample_index,
  input  logic [1:0] in_channel,
  input  logic signed [15:0] in_sample_value,
  input  logic in_value_missing,
  output logic signed [15:0] out_stored_value,
  output logic [15:0] out_hit_count,
  output logic out_range_error,
  input  ows_pkg::ows_cmd_t cmd,
  output ows_pkg::ows_sts_t sts
);
  import ows_pkg::*;
  localparam int DEPTH = OUT_SAMPLES * MAX_CHANNELS;
  localparam int AW = $clog2(DEPTH);

  logic [15:0] mem_v [DEPTH];
  logic [15:0] mem_c [DEPTH];

  logic mode_r;
  logic [2:0] chans_r;
  logic [12:0] wlen_r;
  logic [AW-1:0] clr_addr_r;

  logic op_r, miss_r, err_r;
  logic signed [15:0] x_r;
  logic [AW-1:0] addr_r;
  logic [15:0] rv_r, rc_r;
  logic signed [15:0] val_r;
  logic [15:0] cnt_r;
  // divider: magnitude of diff over count
  logic [16:0] quo_r, rem_r;
  logic neg_r;
  // value written back: old value plus signed quotient in avg mode
  logic signed [15:0] wr_val;

  assign wr_val = mode_r ? val_r
                         : val_r + (neg_r ? -$signed(quo_r[15:0]) : $signed(quo_r[15:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      chans_r <= 3'd3;
      wlen_r <= 13'd3000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_STACK_MODE: mode_r <= cfg_wdata[0];
        REG_CHANNELS: chans_r <= cfg_wdata[2:0];
        REG_WIN_LEN: wlen_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
  end
  assign sts.clr_done = (clr_addr_r == AW'(DEPTH - 1));

  // range check and address
  logic [12:0] pos;
  logic [4:0] chans_eff;
  logic in_err;
  always_comb begin
    pos = {1'b0, in_window_offset} + {1'b0, in_sample_index};
    chans_eff = (32'(chans_r) > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : 5'(chans_r);
    in_err = ({1'b0, in_sample_index} >= wlen_r) || (5'(in_channel) >= chans_eff)
             || (32'(pos) >= OUT_SAMPLES);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      miss_r <= in_value_missing;
      x_r <= in_sample_value;
      err_r <= in_err;
      addr_r <= AW'(({19'd0, pos} * 32'(MAX_CHANNELS)) + 32'(in_channel));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem_v[clr_addr_r] <= '0;
      mem_c[clr_addr_r] <= '0;
    end else if (cmd.wr) begin
      mem_v[addr_r] <= wr_val;
      mem_c[addr_r] <= cnt_r;
    end
    rv_r <= mem_v[addr_r];
    rc_r <= mem_c[addr_r];
  end

  assign sts.err = err_r;
  assign sts.skip = op_r || miss_r || (mode_r && !(x_r > $signed(rv_r)));
  assign sts.need_div = !mode_r;

  logic [15:0] cnt_inc;
  logic signed [16:0] diff;
  logic [16:0] trial;
  assign cnt_inc = (rc_r == 16'hFFFF) ? rc_r : rc_r + 16'd1;
  assign diff = 17'(x_r) - 17'($signed(rv_r));
  assign trial = {rem_r[15:0], quo_r[16]};

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      val_r <= '0;
      cnt_r <= '0;
    end else if (cmd.eval) begin
      val_r <= $signed(rv_r);
      cnt_r <= rc_r;
      if (!sts.skip) begin
        if (mode_r) val_r <= x_r;
        else begin
          cnt_r <= cnt_inc;
          neg_r <= diff[16];
          quo_r <= diff[16] ? 17'(-diff) : 17'(diff);
          rem_r <= '0;
        end
      end
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, cnt_r}) begin
        rem_r <= trial - {1'b0, cnt_r};
        quo_r <= {quo_r[15:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[15:0], 1'b0};
      end
    end else if (cmd.wr) begin
      val_r <= wr_val;
    end
  end

  // after a write the entry equals val_r/cnt_r; err path cleared by rd
  assign out_stored_value = val_r;
  assign out_hit_count = cnt_r;
  assign out_range_error = err_r;
endmodule
